/* rtl/esfd_pkg.sv */
// ----------------------------------------------------------------------------
// esfd_pkg
// Types and constants for the escaped sync frame deframer.
// ----------------------------------------------------------------------------
package esfd_pkg;

  localparam logic [7:0] EscapeByte = 8'hD0;
  localparam logic [7:0] SyncByte   = 8'hE0;

  typedef enum logic [1:0] {
    PH_ID   = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] node_id;
    logic [7:0] byte_index;
    logic [7:0] frame_length;
    logic       last_of_frame;
  } result_t;

endpackage

/* rtl/esfd_in_stage.sv */
// ----------------------------------------------------------------------------
// esfd_in_stage
// Input register: captures one raw line byte per transaction.
// ----------------------------------------------------------------------------
module esfd_in_stage import esfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       advance_i,
  output logic       item_valid_o,
  output logic [7:0] item_byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       load;

  assign in_stall_o = valid_q && !advance_i;
  assign load       = !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (load) begin
      valid_d = in_valid_i;
      if (in_valid_i) begin
        byte_d = rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign item_valid_o = valid_q;
  assign item_byte_o  = byte_q;

endmodule

/* rtl/esfd_core.sv */
// ----------------------------------------------------------------------------
// esfd_core
// Frame state and per-byte decode: escape, sync, id, length and data bytes.
// ----------------------------------------------------------------------------
module esfd_core import esfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] raw_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  phase_e     phase_q, phase_d;
  logic       esc_q, esc_d;
  logic [7:0] node_q, node_d;
  logic [7:0] len_q, len_d;
  logic [7:0] cnt_q, cnt_d;

  logic       is_esc;
  logic       is_sync;
  logic [7:0] val;
  logic [7:0] cnt_inc;
  logic       last;

  assign is_esc  = (raw_i == EscapeByte);
  assign is_sync = !esc_q && (raw_i == SyncByte);
  assign val     = esc_q ? raw_i + 8'd1 : raw_i;
  assign cnt_inc = cnt_q + 8'd1;
  assign last    = (cnt_inc >= len_q);

  // next state
  always_comb begin
    phase_d = phase_q;
    esc_d   = esc_q;
    node_d  = node_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    if (take_i) begin
      if (is_esc) begin
        esc_d = 1'b1;
      end else begin
        esc_d = 1'b0;
        if (is_sync) begin
          phase_d = PH_ID;
          len_d   = 8'd0;
          cnt_d   = 8'd0;
        end else begin
          case (phase_q)
            PH_LEN: begin
              len_d   = val;
              cnt_d   = 8'd0;
              phase_d = PH_DATA;
            end
            PH_DATA: begin
              cnt_d = cnt_inc;
              if (last) begin
                phase_d = PH_DONE;
              end
            end
            default: begin
              len_d   = 8'd0;
              cnt_d   = 8'd0;
              node_d  = val;
              phase_d = PH_LEN;
            end
          endcase
        end
      end
    end
  end

  // outputs
  always_comb begin
    res_valid_o        = take_i && !is_esc && !is_sync && (phase_q == PH_DATA);
    res_o.data_byte    = val;
    res_o.node_id      = node_q;
    res_o.byte_index   = cnt_q;
    res_o.frame_length = len_q;
    res_o.last_of_frame = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ID;
      esc_q   <= 1'b0;
      node_q  <= 8'd0;
      len_q   <= 8'd0;
      cnt_q   <= 8'd0;
    end else begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      node_q  <= node_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

  a_data_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (cnt_q < len_q || cnt_q == 8'd0))
    else $error("data phase count beyond frame length");

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last_of_frame) |=> (phase_q == PH_DONE))
    else $error("last byte did not close the frame");

  a_header_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_ID || phase_q == PH_LEN) |-> (cnt_q == 8'd0 && len_q == 8'd0))
    else $error("header phase with stale length or count");

endmodule

/* rtl/esfd_out_stage.sv */
// ----------------------------------------------------------------------------
// esfd_out_stage
// Result register: holds one decoded payload byte until the sink takes it.
// ----------------------------------------------------------------------------
module esfd_out_stage import esfd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    ready_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_o
);

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (ready_o) begin
      valid_d = res_valid_i;
      if (res_valid_i) begin
        res_d = res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule

/* rtl/escaped_sync_frame_deframer.sv */
// ----------------------------------------------------------------------------
// escaped_sync_frame_deframer
// Splits an escaped, sync-delimited byte stream into frames and streams out
// each payload byte tagged with node id, index, length and a last flag.
// Path: input transaction to result through the input reg, then the result reg.
// Throughput: one byte per cycle while the output is not stalled.
// Reset: asynchronous, active low; empties both registers and sets the frame
// state to expect an id byte with no escape pending.
// ----------------------------------------------------------------------------
module escaped_sync_frame_deframer import esfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_byte_o,
  output logic [7:0] node_id_o,
  output logic [7:0] byte_index_o,
  output logic [7:0] frame_length_o,
  output logic       last_of_frame_o
);

  logic       item_valid;
  logic [7:0] item_byte;
  logic       out_ready;
  logic       take;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  assign take = item_valid && out_ready;

  esfd_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .advance_i    (out_ready),
    .item_valid_o (item_valid),
    .item_byte_o  (item_byte)
  );

  esfd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .raw_i       (item_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  esfd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign data_byte_o     = out_res.data_byte;
  assign node_id_o       = out_res.node_id;
  assign byte_index_o    = out_res.byte_index;
  assign frame_length_o  = out_res.frame_length;
  assign last_of_frame_o = out_res.last_of_frame;

endmodule
